// ===== hw/rtl/comb_sort_engine_assert.svh =====
// ----------------------------------------------------------------------------
// comb_sort_engine_assert - assertion macros
// Shorthand for the clocked implication checks used by the engine's checker.
// ----------------------------------------------------------------------------
`ifndef COMB_SORT_ENGINE_ASSERT_SVH
`define COMB_SORT_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CSE_ASSERT_IMPL(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CSE_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/cse_pkg.sv =====
// ----------------------------------------------------------------------------
// cse_pkg - shared definitions for the comb sort engine
// Widths, queue entry layout, store word layout and the sorter state type.
// ----------------------------------------------------------------------------
package cse_pkg;

    localparam int unsigned MAX_ITEMS_DEF = 64;
    localparam int unsigned KEY_W         = 32;
    localparam int unsigned TAG_W         = 8;
    // Power of two, so the queue pointers wrap on their own.
    localparam int unsigned QUEUE_DEPTH   = 4;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
        logic             last;
        logic             keep;
        logic             ovf;
    } queue_entry_t;

    typedef struct packed {
        logic         valid;
        queue_entry_t entry;
    } queue_push_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } store_word_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PASS,
        ST_READ,
        ST_COMPARE,
        ST_SWAP,
        ST_EMIT_RD,
        ST_EMIT_OUT
    } back_state_t;

endpackage

// ===== hw/rtl/cse_fifo.sv =====
// ----------------------------------------------------------------------------
// cse_fifo - decoupling queue
// Short register queue between the input classifier and the sorter.
// ----------------------------------------------------------------------------
module cse_fifo
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cse_pkg::queue_push_t push,
    output logic                 full,
    output logic                 head_valid,
    output cse_pkg::queue_entry_t head,
    input  logic                 pop
);
    import cse_pkg::*;

    localparam int unsigned PW = $clog2(QUEUE_DEPTH);

    queue_entry_t   slot_reg [QUEUE_DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg;
    logic [PW-1:0]  rd_ptr_next;
    logic [PW:0]    fill_reg;
    logic [PW:0]    fill_next;
    logic           do_push;
    logic           do_pop;

    assign full       = (fill_reg == (PW+1)'(QUEUE_DEPTH));
    assign head_valid = (fill_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];
    assign do_push    = push.valid && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + (PW+1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - (PW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push.entry;
        end
    end

endmodule

// ===== hw/rtl/cse_front.sv =====
// ----------------------------------------------------------------------------
// cse_front - input classifier
// Counts the items of a set, drops those beyond capacity and tags each beat.
// ----------------------------------------------------------------------------
module cse_front
#(
    parameter int unsigned MAX_ITEMS = cse_pkg::MAX_ITEMS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [cse_pkg::KEY_W-1:0]    item_key,
    input  logic [cse_pkg::TAG_W-1:0]    item_tag,
    input  logic                         item_last,
    input  logic                         queue_full,
    output cse_pkg::queue_push_t         push
);
    import cse_pkg::*;

    localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          ovf_reg;
    logic          ovf_next;
    logic          accept;
    logic          room;

    assign in_ready = !queue_full;
    assign accept   = in_valid && !queue_full;
    assign room     = (count_reg < CW'(MAX_ITEMS));

    // A closing beat is always queued, even when its item is dropped,
    // so the sorter learns where the set ends.
    always_comb
    begin
        push.valid       = accept && (item_last || room);
        push.entry.key   = item_key;
        push.entry.tag   = item_tag;
        push.entry.last  = item_last;
        push.entry.keep  = room;
        push.entry.ovf   = ovf_reg || !room;
    end

    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (accept)
        begin
            if (item_last)
            begin
                count_next = '0;
                ovf_next   = 1'b0;
            end
            else if (room)
            begin
                count_next = count_reg + CW'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

// ===== hw/rtl/cse_back.sv =====
// ----------------------------------------------------------------------------
// cse_back - store, comb sort sequencer and output stage
// Loads queued items into the store, sorts them in place, then reads them out.
// ----------------------------------------------------------------------------
module cse_back
#(
    parameter int unsigned MAX_ITEMS = cse_pkg::MAX_ITEMS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         head_valid,
    input  cse_pkg::queue_entry_t        head,
    output logic                         pop,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [cse_pkg::KEY_W-1:0]    out_key,
    output logic [cse_pkg::TAG_W-1:0]    out_tag,
    output logic                         out_last,
    output logic                         overflow
);
    import cse_pkg::*;

    localparam int unsigned AW = $clog2(MAX_ITEMS);
    localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

    store_word_t   store_mem [MAX_ITEMS];

    back_state_t   state_reg;
    back_state_t   state_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [CW-1:0] gap_reg;
    logic [CW-1:0] gap_next;
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] idx_next;
    logic          swap_reg;
    logic          swap_next;
    logic          ovf_reg;
    logic          ovf_next;
    store_word_t   rd_a_reg;
    store_word_t   rd_b_reg;

    logic [CW-1:0] partner;
    logic [CW-1:0] load_count;
    logic          pair_ok;
    logic          less;
    logic          is_final;
    logic          sort_done;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    store_word_t   wr_data;
    logic          rd_en;

    assign partner    = idx_reg + gap_reg;
    assign pair_ok    = (partner < count_reg);
    assign less       = (rd_b_reg.key < rd_a_reg.key);
    assign is_final   = ((idx_reg + CW'(1)) == count_reg);
    assign sort_done  = !swap_reg && (gap_reg <= CW'(1));
    assign load_count = count_reg + CW'(head.keep);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (head_valid && head.last)
                begin
                    state_next = ST_PASS;
                end
            end
            ST_PASS:
            begin
                state_next = sort_done ? ST_EMIT_RD : ST_READ;
            end
            ST_READ:
            begin
                state_next = pair_ok ? ST_COMPARE : ST_PASS;
            end
            ST_COMPARE:
            begin
                state_next = less ? ST_SWAP : ST_READ;
            end
            ST_SWAP:
            begin
                state_next = ST_READ;
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_OUT;
            end
            ST_EMIT_OUT:
            begin
                if (out_ready)
                begin
                    state_next = is_final ? ST_LOAD : ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        pop        = 1'b0;
        out_valid  = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = idx_reg[AW-1:0];
        wr_data    = rd_b_reg;
        rd_en      = 1'b0;
        count_next = count_reg;
        gap_next   = gap_reg;
        idx_next   = idx_reg;
        swap_next  = swap_reg;
        ovf_next   = ovf_reg;
        case (state_reg)
            ST_LOAD:
            begin
                pop = head_valid;
                if (head_valid)
                begin
                    if (head.keep)
                    begin
                        wr_en       = 1'b1;
                        wr_addr     = count_reg[AW-1:0];
                        wr_data.key = head.key;
                        wr_data.tag = head.tag;
                    end
                    count_next = load_count;
                    if (head.last)
                    begin
                        ovf_next  = head.ovf;
                        gap_next  = load_count;
                        swap_next = 1'b1;
                    end
                end
            end
            ST_PASS:
            begin
                idx_next = '0;
                if (!sort_done)
                begin
                    gap_next  = CW'(({1'b0, gap_reg} + (CW+1)'(1)) >> 1);
                    swap_next = 1'b0;
                end
            end
            ST_READ:
            begin
                rd_en = pair_ok;
            end
            ST_COMPARE:
            begin
                if (less)
                begin
                    wr_en     = 1'b1;
                    wr_addr   = idx_reg[AW-1:0];
                    wr_data   = rd_b_reg;
                    swap_next = 1'b1;
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                end
            end
            ST_SWAP:
            begin
                wr_en    = 1'b1;
                wr_addr  = partner[AW-1:0];
                wr_data  = rd_a_reg;
                idx_next = idx_reg + CW'(1);
            end
            ST_EMIT_RD:
            begin
                rd_en = 1'b1;
            end
            ST_EMIT_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (is_final)
                    begin
                        count_next = '0;
                        gap_next   = '0;
                        swap_next  = 1'b0;
                        ovf_next   = 1'b0;
                    end
                    else
                    begin
                        idx_next = idx_reg + CW'(1);
                    end
                end
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            gap_reg   <= '0;
            idx_reg   <= '0;
            swap_reg  <= 1'b0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            gap_reg   <= gap_next;
            idx_reg   <= idx_next;
            swap_reg  <= swap_next;
            ovf_reg   <= ovf_next;
        end
    end

    // One write port, two registered read ports; reads and writes never
    // fall in the same cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_a_reg <= store_mem[idx_reg[AW-1:0]];
            rd_b_reg <= store_mem[partner[AW-1:0]];
        end
    end

    assign out_key  = rd_a_reg.key;
    assign out_tag  = rd_a_reg.tag;
    assign out_last = is_final;
    assign overflow = ovf_reg;

endmodule

// ===== hw/rtl/comb_sort_engine.sv =====
// ----------------------------------------------------------------------------
// comb_sort_engine - collects a set of keyed items, comb sorts, emits in order
// Input: one beat a cycle while the 4-entry queue has room; loading drains it at one a cycle.
// Sort: each pass is PASS, then READ and COMPARE per pair (plus SWAP on an exchange) and a last READ.
// Output: each beat is read from the single store, then held on the port until taken.
// Reset (rst_n, async, low) empties queue and counters; the store itself is not cleared.
// ----------------------------------------------------------------------------
module comb_sort_engine
#(
    parameter int unsigned MAX_ITEMS = cse_pkg::MAX_ITEMS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [cse_pkg::KEY_W-1:0]    item_key,
    input  logic [cse_pkg::TAG_W-1:0]    item_tag,
    input  logic                         item_last,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [cse_pkg::KEY_W-1:0]    out_key,
    output logic [cse_pkg::TAG_W-1:0]    out_tag,
    output logic                         out_last,
    output logic                         overflow
);
    import cse_pkg::*;

    // The engine is split into three parts.
    //
    // The front counts the beats of the current set. Beats that fit in the
    // store are queued for loading; beats beyond capacity are dropped and
    // only set the overflow flag, except the closing beat, which is always
    // queued (marked as not to be stored when the store is full) so that the
    // back end knows where the set ends and whether anything was lost.
    //
    // The queue decouples the two sides: the front keeps taking beats of the
    // next set while the back end is still sorting or emitting, until the
    // queue fills.
    //
    // The back end writes queued items into its store, one per cycle while any
    // are queued. On the closing beat it runs the comb sort: each pass halves
    // the gap, rounding up, and walks the index from zero, reading the pair
    // (i, i + gap) on both read ports, comparing the registered words and,
    // when the upper key is strictly smaller, writing the two words back in
    // COMPARE and SWAP. Sorting stops after a pass with a gap of one that made
    // no exchange. The sorted items are then read out one at a time; the read
    // register doubles as the output register and holds while the sink stalls.

    queue_push_t  queue_push;
    queue_entry_t queue_head;
    logic         queue_full;
    logic         queue_head_valid;
    logic         queue_pop;

    cse_front
    #(
        .MAX_ITEMS (MAX_ITEMS)
    )
    u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .item_key   (item_key),
        .item_tag   (item_tag),
        .item_last  (item_last),
        .queue_full (queue_full),
        .push       (queue_push)
    );

    cse_fifo u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (queue_push),
        .full       (queue_full),
        .head_valid (queue_head_valid),
        .head       (queue_head),
        .pop        (queue_pop)
    );

    cse_back
    #(
        .MAX_ITEMS (MAX_ITEMS)
    )
    u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (queue_head_valid),
        .head       (queue_head),
        .pop        (queue_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_key    (out_key),
        .out_tag    (out_tag),
        .out_last   (out_last),
        .overflow   (overflow)
    );

endmodule

// ===== hw/rtl/cse_checker.sv =====
// ----------------------------------------------------------------------------
// cse_checker - port-level checks for the comb sort engine
// Watches the output channel for stall behaviour, ordering and a steady overflow flag within a set.
// ----------------------------------------------------------------------------
`include "comb_sort_engine_assert.svh"

module cse_checker
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic [cse_pkg::KEY_W-1:0]    out_key,
    input  logic [cse_pkg::TAG_W-1:0]    out_tag,
    input  logic                         out_last,
    input  logic                         overflow
);
    import cse_pkg::*;

    logic [KEY_W-1:0] prev_key_reg;
    logic             prev_ovf_reg;
    logic             mid_set_reg;
    logic             mid_set_next;
    logic             out_beat;

    assign out_beat     = out_valid && out_ready;
    assign mid_set_next = out_beat ? !out_last : mid_set_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_set_reg <= 1'b0;
        end
        else
        begin
            mid_set_reg <= mid_set_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_beat)
        begin
            prev_key_reg <= out_key;
            prev_ovf_reg <= overflow;
        end
    end

    `CSE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "output beat withdrawn while stalled")
    `CSE_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_key) && $stable(out_tag) && $stable(out_last) && $stable(overflow), "output payload changed while stalled")
    `CSE_ASSERT_IMPL(a_ascending, clk, rst_n, out_valid && mid_set_reg, out_key >= prev_key_reg, "output keys out of order within a set")
    `CSE_ASSERT_IMPL(a_ovf_steady, clk, rst_n, out_valid && mid_set_reg, overflow == prev_ovf_reg, "overflow flag changed within a set")

endmodule

bind comb_sort_engine cse_checker u_cse_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_key   (out_key),
    .out_tag   (out_tag),
    .out_last  (out_last),
    .overflow  (overflow)
);
